// ===== sv/dll_pkg.sv =====
// Package for the doubly linked list block: operation codes and error codes.
// No dependencies; imported by the top level doubly_linked_list_with_cursor.
`default_nettype none

package dll_pkg;

  // Operation codes carried by in_mode. Codes above OP_PREV do nothing.
  typedef enum logic [4:0] {
    OP_CLEAR      = 5'd0,
    OP_INS_HEAD   = 5'd1,
    OP_INS_TAIL   = 5'd2,
    OP_CUR_HEAD   = 5'd3,
    OP_CUR_TAIL   = 5'd4,
    OP_RD_HEAD    = 5'd5,
    OP_RD_TAIL    = 5'd6,
    OP_DEL_HEAD   = 5'd7,
    OP_DEL_TAIL   = 5'd8,
    OP_DEL_AFTER  = 5'd9,
    OP_DEL_BEFORE = 5'd10,
    OP_INS_AFTER  = 5'd11,
    OP_INS_BEFORE = 5'd12,
    OP_RD_CUR     = 5'd13,
    OP_WR_CUR     = 5'd14,
    OP_NEXT       = 5'd15,
    OP_PREV       = 5'd16
  } op_t;

  // Error codes reported with every result.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== sv/dll_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; used for the node value, next and prev stores.
`default_nettype none

module dll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; a read of a location being written
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/doubly_linked_list_with_cursor.sv =====
// Doubly linked list of signed 32-bit values in a node pool, with head, tail and cursor.
// Depends on dll_pkg (operation and error codes) and dll_ram (node stores).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | start high, busy low | in_mode, in_value
//   result   | out_valid strobe     | out_read_value, out_error_code, out_cursor_active
//
// Every operation steps through S_RA, S_RB, S_W1 and S_W2 from acceptance to
// the result strobe: S_RA and S_RB carry two dependent pointer reads through
// the registered-read node memories, and S_W1 and S_W2 write back, since some
// operations write the next store at two different nodes. busy is high from
// acceptance through S_W2; a new transaction may start in the cycle the
// result is shown. The receiver cannot stall. Reset empties the list and the
// free pool, and needs no pass over the node memories.
`default_nettype none

module doubly_linked_list_with_cursor #(
  parameter int NODE_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  in_mode,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [31:0]      out_read_value,
  output logic [1:0]       out_error_code,
  output logic             out_cursor_active
);

  import dll_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam logic [IW:0] POOL_SIZE = (IW+1)'(NODE_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RA,
    S_RB,
    S_W1,
    S_W2
  } state_t;

  state_t         state_r, state_nxt;
  logic [4:0]     op_r, op_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [IW-1:0]  a_r, a_nxt;
  logic [IW-1:0]  b_r, b_nxt;
  logic [31:0]    rd_r, rd_nxt;
  logic [IW-1:0]  head_r, head_nxt;
  logic [IW-1:0]  tail_r, tail_nxt;
  logic [IW-1:0]  cur_r, cur_nxt;
  logic           ne_r, ne_nxt;
  logic           cv_r, cv_nxt;
  logic [IW-1:0]  fh_r, fh_nxt;
  logic           flv_r, flv_nxt;
  logic [IW:0]    nuc_r, nuc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_rv_r, out_rv_nxt;
  logic [1:0]     out_err_r, out_err_nxt;
  logic           out_ca_r, out_ca_nxt;

  // Node store ports.
  logic           val_we, nxt_we, prv_we;
  logic [IW-1:0]  val_waddr, nxt_waddr, prv_waddr;
  logic [31:0]    val_wdata;
  logic [IW-1:0]  nxt_wdata, prv_wdata;
  logic [IW-1:0]  val_raddr, nxt_raddr, prv_raddr;
  logic [31:0]    val_rdata;
  logic [IW-1:0]  nxt_rdata, prv_rdata;

  // Decoded conditions; registers they use stay fixed until the last cycle.
  logic           is_ins, take_ok, ins_go, del_after_go, del_before_go;
  logic [IW-1:0]  new_idx;
  logic [1:0]     err;

  dll_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(val_rdata)
  );

  dll_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata)
  );

  dll_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(prv_raddr), .rdata(prv_rdata)
  );

  // Operation decode and node allocation choice.
  always_comb begin
    is_ins = (op_r == OP_INS_HEAD) || (op_r == OP_INS_TAIL) ||
             (((op_r == OP_INS_AFTER) || (op_r == OP_INS_BEFORE)) && cv_r);
    take_ok = flv_r || (nuc_r < POOL_SIZE);
    ins_go = is_ins && take_ok;
    new_idx = flv_r ? fh_r : nuc_r[IW-1:0];
    del_after_go = cv_r && (cur_r != tail_r);
    del_before_go = cv_r && (cur_r != head_r);
    err = ERR_NONE;
    if (is_ins && !take_ok) begin
      err = ERR_FULL;
    end else if (((op_r == OP_RD_HEAD) || (op_r == OP_RD_TAIL)) && !ne_r) begin
      err = ERR_EMPTY;
    end else if ((op_r == OP_RD_CUR) && !cv_r) begin
      err = ERR_EMPTY;
    end
  end

  // Read addresses: first reads in S_RA, dependent second reads in S_RB.
  always_comb begin
    val_raddr = cur_r;
    nxt_raddr = fh_r;
    prv_raddr = cur_r;
    if (state_r == S_RB) begin
      nxt_raddr = (op_r == OP_DEL_AFTER) ? nxt_rdata : cur_r;
      prv_raddr = (op_r == OP_DEL_BEFORE) ? prv_rdata : cur_r;
    end else begin
      if (op_r == OP_RD_HEAD) begin
        val_raddr = head_r;
      end else if (op_r == OP_RD_TAIL) begin
        val_raddr = tail_r;
      end
      if (op_r == OP_DEL_HEAD) begin
        nxt_raddr = head_r;
      end else if ((op_r == OP_DEL_AFTER) || (op_r == OP_NEXT)) begin
        nxt_raddr = cur_r;
      end
      if (op_r == OP_DEL_TAIL) begin
        prv_raddr = tail_r;
      end
    end
  end

  // Write-back to the node stores in S_W1 and S_W2.
  always_comb begin
    val_we = 1'b0;
    val_waddr = new_idx;
    val_wdata = val_r;
    nxt_we = 1'b0;
    nxt_waddr = new_idx;
    nxt_wdata = head_r;
    prv_we = 1'b0;
    prv_waddr = new_idx;
    prv_wdata = tail_r;
    if (state_r == S_W1) begin
      case (op_r)
        OP_INS_HEAD, OP_INS_TAIL: begin
          val_we = ins_go;
          if (ins_go && ne_r) begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
            if (op_r == OP_INS_HEAD) begin
              nxt_waddr = new_idx;
              nxt_wdata = head_r;
              prv_waddr = head_r;
              prv_wdata = new_idx;
            end else begin
              nxt_waddr = tail_r;
              nxt_wdata = new_idx;
              prv_waddr = new_idx;
              prv_wdata = tail_r;
            end
          end
        end
        OP_DEL_HEAD, OP_DEL_TAIL: begin
          // Return the removed end node to the free chain.
          nxt_we = ne_r;
          nxt_waddr = (op_r == OP_DEL_HEAD) ? head_r : tail_r;
          nxt_wdata = flv_r ? fh_r : nxt_waddr;
        end
        OP_DEL_AFTER: begin
          nxt_we = del_after_go;
          nxt_waddr = cur_r;
          nxt_wdata = nxt_rdata;
          prv_we = del_after_go && (tail_r != a_r);
          prv_waddr = nxt_rdata;
          prv_wdata = cur_r;
        end
        OP_DEL_BEFORE: begin
          prv_we = del_before_go;
          prv_waddr = cur_r;
          prv_wdata = prv_rdata;
          nxt_we = del_before_go && (head_r != a_r);
          nxt_waddr = prv_rdata;
          nxt_wdata = cur_r;
        end
        OP_INS_AFTER: begin
          val_we = ins_go;
          nxt_we = ins_go;
          nxt_waddr = new_idx;
          nxt_wdata = nxt_rdata;
          prv_we = ins_go;
          prv_waddr = new_idx;
          prv_wdata = cur_r;
        end
        OP_INS_BEFORE: begin
          val_we = ins_go;
          prv_we = ins_go;
          prv_waddr = new_idx;
          prv_wdata = prv_rdata;
          nxt_we = ins_go;
          nxt_waddr = new_idx;
          nxt_wdata = cur_r;
        end
        OP_WR_CUR: begin
          val_we = cv_r;
          val_waddr = cur_r;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_W2) begin
      case (op_r)
        OP_DEL_AFTER, OP_DEL_BEFORE: begin
          nxt_we = (op_r == OP_DEL_AFTER) ? del_after_go : del_before_go;
          nxt_waddr = a_r;
          nxt_wdata = flv_r ? fh_r : a_r;
        end
        OP_INS_AFTER: begin
          nxt_we = ins_go;
          nxt_waddr = cur_r;
          nxt_wdata = new_idx;
          prv_we = ins_go && (tail_r != cur_r);
          prv_waddr = b_r;
          prv_wdata = new_idx;
        end
        OP_INS_BEFORE: begin
          prv_we = ins_go;
          prv_waddr = cur_r;
          prv_wdata = new_idx;
          nxt_we = ins_go && (head_r != cur_r);
          nxt_waddr = b_r;
          nxt_wdata = new_idx;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer and list registers; list registers change only in S_W2.
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    val_nxt = val_r;
    a_nxt = a_r;
    b_nxt = b_r;
    rd_nxt = rd_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cur_nxt = cur_r;
    ne_nxt = ne_r;
    cv_nxt = cv_r;
    fh_nxt = fh_r;
    flv_nxt = flv_r;
    nuc_nxt = nuc_r;
    out_valid_nxt = 1'b0;
    out_rv_nxt = out_rv_r;
    out_err_nxt = out_err_r;
    out_ca_nxt = out_ca_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_mode;
          val_nxt = in_value;
          state_nxt = S_RA;
        end
      end
      S_RA: begin
        state_nxt = S_RB;
      end
      S_RB: begin
        // First read results arrive.
        a_nxt = ((op_r == OP_DEL_TAIL) || (op_r == OP_DEL_BEFORE) ||
                 (op_r == OP_PREV)) ? prv_rdata : nxt_rdata;
        rd_nxt = val_rdata;
        state_nxt = S_W1;
      end
      S_W1: begin
        // Second read results arrive.
        b_nxt = ((op_r == OP_DEL_BEFORE) || (op_r == OP_INS_BEFORE)) ?
                prv_rdata : nxt_rdata;
        state_nxt = S_W2;
      end
      S_W2: begin
        // Node allocation for inserts.
        if (ins_go) begin
          if (flv_r) begin
            if (a_r == fh_r) begin
              flv_nxt = 1'b0;
            end else begin
              fh_nxt = a_r;
            end
          end else begin
            nuc_nxt = nuc_r + {{IW{1'b0}}, 1'b1};
          end
        end
        case (op_r)
          OP_CLEAR: begin
            ne_nxt = 1'b0;
            cv_nxt = 1'b0;
            flv_nxt = 1'b0;
            nuc_nxt = '0;
          end
          OP_INS_HEAD, OP_INS_TAIL: begin
            if (ins_go) begin
              if (!ne_r) begin
                head_nxt = new_idx;
                tail_nxt = new_idx;
                ne_nxt = 1'b1;
              end else if (op_r == OP_INS_HEAD) begin
                head_nxt = new_idx;
              end else begin
                tail_nxt = new_idx;
              end
            end
          end
          OP_CUR_HEAD: begin
            cur_nxt = head_r;
            cv_nxt = ne_r;
          end
          OP_CUR_TAIL: begin
            cur_nxt = tail_r;
            cv_nxt = ne_r;
          end
          OP_DEL_HEAD, OP_DEL_TAIL: begin
            if (ne_r) begin
              if (op_r == OP_DEL_HEAD) begin
                if (cv_r && (cur_r == head_r)) begin
                  cv_nxt = 1'b0;
                end
                fh_nxt = head_r;
                head_nxt = a_r;
              end else begin
                if (cv_r && (cur_r == tail_r)) begin
                  cv_nxt = 1'b0;
                end
                fh_nxt = tail_r;
                tail_nxt = a_r;
              end
              if (head_r == tail_r) begin
                ne_nxt = 1'b0;
                head_nxt = head_r;
                tail_nxt = tail_r;
              end
              flv_nxt = 1'b1;
            end
          end
          OP_DEL_AFTER: begin
            if (del_after_go) begin
              if (tail_r == a_r) begin
                tail_nxt = cur_r;
              end
              fh_nxt = a_r;
              flv_nxt = 1'b1;
            end
          end
          OP_DEL_BEFORE: begin
            if (del_before_go) begin
              if (head_r == a_r) begin
                head_nxt = cur_r;
              end
              fh_nxt = a_r;
              flv_nxt = 1'b1;
            end
          end
          OP_INS_AFTER: begin
            if (ins_go && (tail_r == cur_r)) begin
              tail_nxt = new_idx;
            end
          end
          OP_INS_BEFORE: begin
            if (ins_go && (head_r == cur_r)) begin
              head_nxt = new_idx;
            end
          end
          OP_NEXT: begin
            if (cv_r) begin
              if (cur_r == tail_r) begin
                cv_nxt = 1'b0;
              end else begin
                cur_nxt = a_r;
              end
            end
          end
          OP_PREV: begin
            if (cv_r) begin
              if (cur_r == head_r) begin
                cv_nxt = 1'b0;
              end else begin
                cur_nxt = a_r;
              end
            end
          end
          default: begin
          end
        endcase
        // Result of the transaction.
        out_valid_nxt = 1'b1;
        out_err_nxt = err;
        out_rv_nxt = '0;
        if (((op_r == OP_RD_HEAD) || (op_r == OP_RD_TAIL) || (op_r == OP_RD_CUR)) &&
            (err == ERR_NONE)) begin
          out_rv_nxt = rd_r;
        end
        out_ca_nxt = cv_nxt;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      tail_r <= '0;
      cur_r <= '0;
      ne_r <= 1'b0;
      cv_r <= 1'b0;
      fh_r <= '0;
      flv_r <= 1'b0;
      nuc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cur_r <= cur_nxt;
      ne_r <= ne_nxt;
      cv_r <= cv_nxt;
      fh_r <= fh_nxt;
      flv_r <= flv_nxt;
      nuc_r <= nuc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
    val_r <= val_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    rd_r <= rd_nxt;
    out_rv_r <= out_rv_nxt;
    out_err_r <= out_err_nxt;
    out_ca_r <= out_ca_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_error_code = out_err_r;
  assign out_cursor_active = out_ca_r;

endmodule

`default_nettype wire
